FILE: design/utf32_to_utf16_stream_defines.svh
// Assertion macros shared by the stream transcoder checkers.
`ifndef UTF32_TO_UTF16_STREAM_DEFINES_SVH
`define UTF32_TO_UTF16_STREAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define U32U16_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define U32U16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/u32u16_pkg.sv
// Types and constants shared by the UTF-32 to UTF-16 stream transcoder.
package u32u16_pkg;

  // Mark detection phase
  typedef enum logic [1:0] {
    PH_MARK = 2'd0,
    PH_BODY = 2'd1,
    PH_BAD  = 2'd2
  } phase_t;

  localparam logic [31:0] BOM_BE      = 32'h0000_FEFF;
  localparam logic [31:0] BOM_LE      = 32'hFFFE_0000;
  localparam logic [15:0] BOM16       = 16'hFEFF;
  localparam logic [31:0] SUPP_LO     = 32'h0001_0000;
  localparam logic [31:0] SUPP_HI     = 32'h0010_FFFF;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;  // 0xD800 >> 10
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;  // 0xDC00 >> 10

  // One classified request from the front to the back
  typedef struct packed {
    logic        bad;   // invalid mark: single zero byte
    logic        pair;  // surrogate pair: four bytes
    logic        be;    // big-endian byte order
    logic [15:0] u0;    // first code unit
    logic [15:0] u1;    // second code unit (pair only)
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: design/utf32_to_utf16_stream.sv
// Top level of the UTF-32 to UTF-16 byte stream transcoder.
//
//   channel   direction  handshake     payload
//   input     in         push / full   in_byte, in_new_file
//   result    out        pop / empty   out_byte, out_bad_mark, out_last_of_run
//
// One input byte is taken per cycle while the request queue has room.
// Each completed word queues one request; the back end sends its 1, 2 or 4
// bytes one per cycle while pop takes them, via the output register, so the
// output port sets the long-run rate when surrogate pairs come back to back.
// Reset is synchronous; no clearing pass is needed.
// A stalled output fills the queue (QDEPTH requests), then full rises.
module utf32_to_utf16_stream #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_new_file,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_bad_mark,
  output logic       out_last_of_run
);

  u32u16_pkg::cmd_t    wr_cmd;
  u32u16_pkg::cmd_t    head_cmd;
  u32u16_pkg::q_stat_t q_stat;
  logic                q_push;
  logic                q_pop;

  assign full = q_stat.full;

  u32u16_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_byte     (in_byte),
    .in_new_file (in_new_file),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (wr_cmd)
  );

  u32u16_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (wr_cmd),
    .rd_en   (q_pop),
    .rd_data (head_cmd),
    .stat    (q_stat)
  );

  u32u16_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_head          (head_cmd),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_bad_mark    (out_bad_mark),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: design/u32u16_front.sv
// Front end: gathers bytes into words, checks the mark, classifies characters.
module u32u16_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [7:0]           in_byte,
  input  logic                 in_new_file,
  input  u32u16_pkg::q_stat_t  q_stat,
  output logic                 q_push,
  output u32u16_pkg::cmd_t     q_data
);

  u32u16_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic [23:0]        gat_r, gat_nxt;
  logic               be_r, be_nxt;

  logic               accept;
  u32u16_pkg::phase_t ph;
  logic [1:0]         pos;
  logic [23:0]        gat;
  logic [31:0]        word;
  logic [31:0]        chr;
  logic [31:0]        vfull;
  logic [19:0]        v;

  assign accept = push && !q_stat.full;

  // New file restarts detection with this byte as the first
  assign ph   = in_new_file ? u32u16_pkg::PH_MARK : phase_r;
  assign pos  = in_new_file ? 2'd0 : pos_r;
  assign gat  = in_new_file ? 24'd0 : gat_r;
  assign word = {gat, in_byte};

  // Character value in big-endian order, and its supplementary offset
  assign chr   = be_r ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign vfull = chr - u32u16_pkg::SUPP_LO;
  assign v     = vfull[19:0];

  // Next state and request to the queue
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    gat_nxt   = gat_r;
    be_nxt    = be_r;
    q_push    = 1'b0;
    q_data    = '0;
    q_data.be = be_r;
    if (accept) begin
      phase_nxt = ph;
      pos_nxt   = pos;
      gat_nxt   = gat;
      case (ph)
        u32u16_pkg::PH_MARK, u32u16_pkg::PH_BODY: begin
          if (pos != 2'd3) begin
            gat_nxt = {gat[15:0], in_byte};
            pos_nxt = pos + 2'd1;
          end else begin
            gat_nxt = 24'd0;
            pos_nxt = 2'd0;
            q_push  = 1'b1;
            if (ph == u32u16_pkg::PH_MARK) begin
              if (word == u32u16_pkg::BOM_BE || word == u32u16_pkg::BOM_LE) begin
                be_nxt    = (word == u32u16_pkg::BOM_BE);
                phase_nxt = u32u16_pkg::PH_BODY;
                q_data.be = (word == u32u16_pkg::BOM_BE);
                q_data.u0 = u32u16_pkg::BOM16;
              end else begin
                phase_nxt  = u32u16_pkg::PH_BAD;
                q_data.bad = 1'b1;
              end
            end else if (chr >= u32u16_pkg::SUPP_LO && chr <= u32u16_pkg::SUPP_HI) begin
              q_data.pair = 1'b1;
              q_data.u0   = {u32u16_pkg::HI_SURR_TAG, v[19:10]};
              q_data.u1   = {u32u16_pkg::LO_SURR_TAG, v[9:0]};
            end else begin
              q_data.u0 = chr[15:0];
            end
          end
        end
        default: begin
          // rejected file: ignore bytes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= u32u16_pkg::PH_MARK;
      pos_r   <= 2'd0;
      be_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      be_r    <= be_nxt;
    end
  end

  // gathered bytes are fully overwritten before use
  always_ff @(posedge clk) begin
    gat_r <= gat_nxt;
  end

endmodule

FILE: design/u32u16_queue.sv
// Short request queue between the front and the back.
module u32u16_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  u32u16_pkg::cmd_t     wr_data,
  input  logic                 rd_en,
  output u32u16_pkg::cmd_t     rd_data,
  output u32u16_pkg::q_stat_t  stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u32u16_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  // Pointer and count update with wrap at DEPTH
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

FILE: design/u32u16_back.sv
// Back end: serializes queued requests into bytes behind an output register.
module u32u16_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u32u16_pkg::cmd_t     q_head,
  input  u32u16_pkg::q_stat_t  q_stat,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output logic [7:0]           out_byte,
  output logic                 out_bad_mark,
  output logic                 out_last_of_run
);

  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        obad_r, obad_nxt;
  logic        olast_r, olast_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        adv, emit, last;
  logic [15:0] unit;
  logic [7:0]  sel;

  // Output register free, or its byte taken this cycle
  assign adv  = !ov_r || pop;
  assign emit = adv && !q_stat.empty;

  assign last = q_head.bad  ? 1'b1 :
                q_head.pair ? (idx_r == 2'd3) : (idx_r == 2'd1);
  assign unit = idx_r[1] ? q_head.u1 : q_head.u0;
  // big-endian sends the high byte first
  assign sel  = (q_head.be ^ idx_r[0]) ? unit[15:8] : unit[7:0];

  assign q_pop = emit && last;

  always_comb begin
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    obad_nxt  = obad_r;
    olast_nxt = olast_r;
    idx_nxt   = idx_r;
    if (adv) begin
      ov_nxt = emit;
    end
    if (emit) begin
      ob_nxt    = q_head.bad ? 8'd0 : sel;
      obad_nxt  = q_head.bad;
      olast_nxt = last;
      idx_nxt   = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r    <= ob_nxt;
    obad_r  <= obad_nxt;
    olast_r <= olast_nxt;
  end

  assign empty           = !ov_r;
  assign out_byte        = ob_r;
  assign out_bad_mark    = obad_r;
  assign out_last_of_run = olast_r;

endmodule

FILE: design/u32u16_chk.sv
// Port-level checker for the transcoder, bound to the top level.
`include "utf32_to_utf16_stream_defines.svh"

module u32u16_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic [7:0] in_byte,
  input logic       in_new_file,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_bad_mark,
  input logic       out_last_of_run
);

  // error request is a single zero byte
  `U32U16_ASSERT_NOW(a_bad_single, !empty && out_bad_mark, out_last_of_run && out_byte == 8'd0, "bad mark result must be a lone zero byte")

  // a run in progress continues with a normal byte
  `U32U16_ASSERT_NEXT(a_run_cont, !empty && pop && !out_last_of_run, !out_bad_mark || empty, "run interrupted by a bad mark result")

  // a result not taken stays put
  `U32U16_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last_of_run), "stalled result changed")

endmodule

bind utf32_to_utf16_stream u32u16_chk u_chk (.*);

FILE: test/utf32_to_utf16_stream_checker.sv
// Checker for the UTF-32 to UTF-16 transcoder: predicts output bytes and compares them.
`timescale 1ns / 100ps

module utf32_to_utf16_stream_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_new_file,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_bad_mark,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         outstanding
);

  // One predicted output byte
  typedef struct packed {
    logic [7:0] data;
    logic       bad;
    logic       last;
  } utf16_byte_t;

  // Predicted transcoder state
  u32u16_pkg::phase_t pr_phase;
  logic [1:0]         pr_pos;
  logic [23:0]        pr_gathered;
  logic               pr_be;

  utf16_byte_t utf16_expected[$];
  utf16_byte_t want;
  utf16_byte_t got;

  // Queue one 16-bit code unit as two bytes in the detected order
  function automatic void queue_unit(input logic [15:0] unit, input logic last);
    if (pr_be) begin
      utf16_expected.push_back('{data: unit[15:8], bad: 1'b0, last: 1'b0});
      utf16_expected.push_back('{data: unit[7:0], bad: 1'b0, last: last});
    end else begin
      utf16_expected.push_back('{data: unit[7:0], bad: 1'b0, last: 1'b0});
      utf16_expected.push_back('{data: unit[15:8], bad: 1'b0, last: last});
    end
  endfunction

  // Advance the predicted state by one input byte, queueing any output bytes
  function automatic void transcode_byte(input logic [7:0] b, input logic nf);
    logic [31:0] word;
    logic [31:0] offs;
    if (nf) begin
      pr_phase    = u32u16_pkg::PH_MARK;
      pr_pos      = 2'd0;
      pr_gathered = 24'd0;
    end
    if (pr_phase != u32u16_pkg::PH_MARK && pr_phase != u32u16_pkg::PH_BODY) return;
    if (pr_pos != 2'd3) begin
      pr_gathered = {pr_gathered[15:0], b};
      pr_pos      = pr_pos + 2'd1;
      return;
    end
    word        = {pr_gathered, b};
    pr_pos      = 2'd0;
    pr_gathered = 24'd0;
    // mark detection
    if (pr_phase == u32u16_pkg::PH_MARK) begin
      if (word == u32u16_pkg::BOM_BE || word == u32u16_pkg::BOM_LE) begin
        pr_be    = (word == u32u16_pkg::BOM_BE);
        pr_phase = u32u16_pkg::PH_BODY;
        queue_unit(u32u16_pkg::BOM16, 1'b1);
      end else begin
        pr_phase = u32u16_pkg::PH_BAD;
        utf16_expected.push_back('{data: 8'h00, bad: 1'b1, last: 1'b1});
      end
      return;
    end
    // body word: bring to numeric order, then encode
    if (!pr_be) word = {word[7:0], word[15:8], word[23:16], word[31:24]};
    if (word >= u32u16_pkg::SUPP_LO && word <= u32u16_pkg::SUPP_HI) begin
      offs = word - u32u16_pkg::SUPP_LO;
      queue_unit({u32u16_pkg::HI_SURR_TAG, offs[19:10]}, 1'b0);
      queue_unit({u32u16_pkg::LO_SURR_TAG, offs[9:0]}, 1'b1);
    end else begin
      queue_unit(word[15:0], 1'b1);
    end
  endfunction

  // Watch both channels on each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      pr_phase    = u32u16_pkg::PH_MARK;
      pr_pos      = 2'd0;
      pr_gathered = 24'd0;
      pr_be       = 1'b0;
      utf16_expected.delete();
    end else begin
      // accepted result against the oldest prediction
      if (pop && !empty) begin
        got = '{data: out_byte, bad: out_bad_mark, last: out_last_of_run};
        if (utf16_expected.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: byte %h bad %b last %b",
                     got.data, got.bad, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = utf16_expected.pop_front();
          if (got.data !== want.data || got.bad !== want.bad || got.last !== want.last) begin
            if (fail_count < 10)
              $display("mismatch: expected byte %h bad %b last %b, got byte %h bad %b last %b",
                       want.data, want.bad, want.last, got.data, got.bad, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // accepted request
      if (push && !full) transcode_byte(in_byte, in_new_file);
    end
    outstanding <= utf16_expected.size();
  end

endmodule

FILE: test/tb_utf32_to_utf16_stream.sv
// Testbench top for the UTF-32 to UTF-16 transcoder: stimulus, handshakes and verdict.
`timescale 1ns / 100ps

module tb_utf32_to_utf16_stream;

  localparam int ITEMS = 370;
  localparam int LIMIT = 100000;
  localparam int DRAIN = 20;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       push        = 1'b0;
  logic [7:0] in_byte     = 8'h00;
  logic       in_new_file = 1'b0;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_bad_mark;
  logic       out_last_of_run;

  int   fail_count;
  int   outstanding;
  int   stim_items = 0;
  logic quiet      = 1'b0;

  always #5 clk = ~clk;

  utf32_to_utf16_stream i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_new_file     (in_new_file),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_bad_mark    (out_bad_mark),
    .out_last_of_run (out_last_of_run)
  );

  utf32_to_utf16_stream_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .in_new_file     (in_new_file),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_bad_mark    (out_bad_mark),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Result side: random stalls, none in the quiet stretch
  always @(posedge clk) begin
    pop <= quiet || ($urandom_range(0, 99) >= 14);
  end

  // Offer one byte with random gaps and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic nf, input bit counts);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    in_byte     <= b;
    in_new_file <= nf;
    @(posedge clk);
    while (full) @(posedge clk);
    if (counts) stim_items++;
    quiet <= (stim_items >= 150 && stim_items < 240);
  endtask

  // Send a 32-bit word in the given byte order; new_file only on its first byte
  task automatic send_word(input logic [31:0] word, input logic be, input logic nf,
                           input bit counts);
    for (int i = 0; i < 4; i++)
      send_byte(be ? word[31 - 8 * i -: 8] : word[8 * i +: 8], nf && (i == 0), counts);
  endtask

  // Random code point, weighted toward the interesting ranges
  function automatic logic [31:0] rand_char();
    logic [31:0] edges[8];
    edges = '{32'h0, 32'hFFFF, u32u16_pkg::SUPP_LO, u32u16_pkg::SUPP_HI,
              u32u16_pkg::SUPP_HI + 32'd1, 32'hD800, 32'hDFFF, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom() & 32'h0000_FFFF;
      4, 5, 6:    return u32u16_pkg::SUPP_LO + $urandom_range(0, 32'h000F_FFFF);
      7:          return edges[3'($urandom_range(0, 7))];
      default:    return $urandom();
    endcase
  endfunction

  // Run-length guard
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int          kind;
    int          nchars;
    logic        be;
    logic [31:0] mark;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // big-endian file straight out of reset, no new_file flag
    send_word({16'h0, u32u16_pkg::BOM16}, 1'b1, 1'b0, 1'b1);
    send_word(u32u16_pkg::SUPP_LO, 1'b1, 1'b0, 1'b1);
    send_word(u32u16_pkg::SUPP_HI, 1'b1, 1'b0, 1'b1);
    // partial word dropped by a new little-endian file
    send_byte(8'h12, 1'b0, 1'b1);
    send_byte(8'h34, 1'b0, 1'b1);
    send_word({16'h0, u32u16_pkg::BOM16}, 1'b0, 1'b1, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1);
    // invalid mark, then a byte that must be ignored
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);

    // random files, mostly well formed
    while (stim_items < ITEMS) begin
      kind = $urandom_range(0, 99);
      be   = 1'($urandom_range(0, 1));
      if (kind < 14) begin
        if (kind < 8) begin
          mark = $urandom();
        end else begin
          mark = {16'h0, u32u16_pkg::BOM16} ^ (32'd1 << $urandom_range(0, 31));
        end
        send_word(mark, be, 1'b1, 1'b1);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        send_word({16'h0, u32u16_pkg::BOM16}, be, 1'b1, 1'b1);
        nchars = $urandom_range(1, 10);
        for (int j = 0; j < nchars; j++) begin
          if ($urandom_range(0, 99) < 4) begin
            // trailing partial word
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            break;
          end
          send_word(rand_char(), be, 1'b0, 1'b1);
        end
      end
    end
    push <= 1'b0;
    @(posedge clk);

    // wait for all predicted bytes, then watch for strays
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
